[rtl/rpa_pkg.sv]
// ----------------------------------------------------------------------------
// rpa_pkg
// Types, constants and codes shared by the relay autotuner modules.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int TEMP_FRAC_BITS = 4;
  localparam int TEMP_W  = 15;
  localparam int PF_W    = 8 + TEMP_FRAC_BITS;
  localparam int FRAC_W  = 16;
  localparam int NUM_W   = 6 + PF_W + 32 + FRAC_W;
  localparam int DEN_W   = 34;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  localparam logic [TEMP_W-1:0] TEMP_MAX = 15'd16383;
  localparam logic [18:0] PI_NUM = 19'd314159;
  localparam logic [18:0] K_P    = 19'd480000;
  localparam logic [29:0] K_I    = 30'd960000000;
  localparam logic [5:0]  K_D    = 6'd60;

  typedef enum logic [1:0] {
    REG_OUTPUT_HIGH   = 2'd0,
    REG_OUTPUT_LOW    = 2'd1,
    REG_CYCLES_NEEDED = 2'd2,
    REG_HYSTERESIS    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_MUL, S_DSTART, S_DWAIT, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_P, OP_Q1, OP_I, OP_D
  } div_op_t;

  typedef struct packed {
    logic    load_in;
    logic    eval;
    logic    mul;
    logic    div_go;
    logic    div_store;
    logic    emit;
    div_op_t op;
  } cmd_t;

  typedef struct packed {
    logic finish;
    logic div_done;
  } status_t;

  typedef struct packed {
    logic               cmd;
    logic [TEMP_W-1:0]  current_temp;
    logic [TEMP_W-1:0]  target_temp;
    logic [31:0]        now_ms;
  } in_t;

  typedef struct packed {
    logic [7:0]  heater_power;
    logic        heater_update;
    logic        busy_res;
    logic        done_res;
    logic        aborted;
    logic [31:0] gain_p;
    logic [31:0] gain_i;
    logic [31:0] gain_d;
  } res_t;

endpackage

[rtl/rpa_if.sv]
// ----------------------------------------------------------------------------
// rpa_if
// Handshake channels for autotuner input and result items.
// ----------------------------------------------------------------------------
interface rpa_in_if import rpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [TEMP_W-1:0] current_temp;
  logic [TEMP_W-1:0] target_temp;
  logic [31:0]       now_ms;
  modport source (output valid, cmd, current_temp, target_temp, now_ms, input ready);
  modport sink   (input valid, cmd, current_temp, target_temp, now_ms, output ready);
endinterface

interface rpa_out_if ();
  logic        valid;
  logic        ready;
  logic [7:0]  heater_power;
  logic        heater_update;
  logic        busy_res;
  logic        done_res;
  logic        aborted;
  logic [31:0] gain_p;
  logic [31:0] gain_i;
  logic [31:0] gain_d;
  modport source (output valid, heater_power, heater_update, busy_res, done_res, aborted,
                  gain_p, gain_i, gain_d, input ready);
  modport sink   (input valid, heater_power, heater_update, busy_res, done_res, aborted,
                  gain_p, gain_i, gain_d, output ready);
endinterface

[rtl/rpa_div.sv]
// ----------------------------------------------------------------------------
// rpa_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rpa_div import rpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, sh[NUM_W-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= num;
      dv  <= den;
      rem <= '0;
      quo <= '0;
    end else if (cnt != '0) begin
      sh  <= {sh[NUM_W-2:0], 1'b0};
      rem <= fits ? DEN_W'(trial - {1'b0, dv}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

[rtl/rpa_dp.sv]
// ----------------------------------------------------------------------------
// rpa_dp
// Datapath: configuration, tuner state, relay decision and gain arithmetic.
// ----------------------------------------------------------------------------
module rpa_dp import rpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  reg_idx_t   cfg_index,
  input  logic [9:0] cfg_data,
  input  in_t        in_item,
  input  cmd_t       cmd,
  output status_t    status,
  output res_t       res
);

  logic [7:0] output_high, output_low, cycles_needed;
  logic [9:0] hysteresis;

  in_t                      item;
  logic                     active, heating;
  logic signed [TEMP_W-1:0] peak_high, peak_low;
  logic [7:0]               cycle_count;
  logic [31:0]              last_switch_ms;

  res_t stage;
  res_t eval_res;

  logic [PF_W-1:0]   pf;
  logic [TEMP_W-1:0] swing;
  logic [31:0]       period;
  logic [DEN_W-1:0]  den;
  logic [NUM_W-1:0]  num_p, num_i, num_d, q1;

  logic signed [TEMP_W-1:0] cur, tgt, ph_n, pl_n;
  logic signed [16:0]       hi_th, lo_th;
  logic signed [15:0]       diff;
  logic [7:0]               cc_n;
  logic [7:0]               p_n;
  logic                     tgt_bad, go_low, go_high;

  logic [NUM_W-1:0] dnum;
  logic [DEN_W-1:0] dden;
  logic             ddone;
  logic [NUM_W-1:0] dquo;
  logic [31:0]      qsat;

  assign cur     = $signed(item.current_temp);
  assign tgt     = $signed(item.target_temp);
  assign tgt_bad = tgt[TEMP_W-1] || (tgt == '0);
  assign ph_n    = (cur > peak_high) ? cur : peak_high;
  assign pl_n    = (cur < peak_low) ? cur : peak_low;
  assign hi_th   = 17'(tgt) + $signed({7'b0, hysteresis});
  assign lo_th   = 17'(tgt) - $signed({7'b0, hysteresis});
  assign go_low  = heating && (17'(cur) > hi_th);
  assign go_high = !heating && (17'(cur) < lo_th);
  assign cc_n    = cycle_count + 8'd1;
  assign diff    = 16'(ph_n) - 16'(pl_n);
  assign p_n     = (output_high > output_low) ? output_high - output_low : 8'd0;

  assign status.finish   = !item.cmd && active && !tgt_bad && go_low && (cc_n >= cycles_needed);
  assign status.div_done = ddone;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_high   <= 8'd200;
      output_low    <= 8'd0;
      cycles_needed <= 8'd5;
      hysteresis    <= 10'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTPUT_HIGH:   output_high   <= cfg_data[7:0];
        REG_OUTPUT_LOW:    output_low    <= cfg_data[7:0];
        REG_CYCLES_NEEDED: cycles_needed <= cfg_data[7:0];
        REG_HYSTERESIS:    hysteresis    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) item <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      heating        <= 1'b1;
      peak_high      <= '0;
      peak_low       <= TEMP_MAX;
      cycle_count    <= '0;
      last_switch_ms <= '0;
    end else if (cmd.eval) begin
      if (item.cmd) begin
        active         <= 1'b1;
        heating        <= 1'b1;
        cycle_count    <= '0;
        peak_high      <= '0;
        peak_low       <= TEMP_MAX;
        last_switch_ms <= item.now_ms;
      end else if (active) begin
        if (tgt_bad) begin
          active <= 1'b0;
        end else begin
          if (go_low && !status.finish) begin
            peak_high <= '0;
            peak_low  <= TEMP_MAX;
          end else begin
            peak_high <= ph_n;
            peak_low  <= pl_n;
          end
          if (go_low) begin
            heating        <= 1'b0;
            cycle_count    <= cc_n;
            last_switch_ms <= item.now_ms;
            if (status.finish) active <= 1'b0;
          end else if (go_high) begin
            heating <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    eval_res = '0;
    if (item.cmd) begin
      eval_res.heater_power  = output_high;
      eval_res.heater_update = 1'b1;
      eval_res.busy_res      = 1'b1;
    end else if (active) begin
      if (tgt_bad) begin
        eval_res.aborted = 1'b1;
      end else if (go_low) begin
        eval_res.heater_power  = output_low;
        eval_res.heater_update = 1'b1;
        eval_res.busy_res      = !status.finish;
        eval_res.done_res      = status.finish;
      end else begin
        eval_res.busy_res = 1'b1;
        if (go_high) begin
          eval_res.heater_power  = output_high;
          eval_res.heater_update = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      stage       <= eval_res;
      swing       <= diff[TEMP_W-1:0];
      period      <= item.now_ms - last_switch_ms;
      pf          <= PF_W'(p_n) << TEMP_FRAC_BITS;
    end else if (cmd.div_store && ddone) begin
      case (cmd.op)
        OP_P:    stage.gain_p <= qsat;
        OP_Q1:   q1 <= dquo;
        OP_I:    stage.gain_i <= qsat;
        OP_D:    stage.gain_d <= qsat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      den   <= DEN_W'(DEN_W'(PI_NUM) * DEN_W'(swing));
      num_p <= NUM_W'(NUM_W'(K_P) * NUM_W'(pf)) << FRAC_W;
      num_i <= NUM_W'(NUM_W'(K_I) * NUM_W'(pf)) << FRAC_W;
      num_d <= NUM_W'(NUM_W'(K_D) * NUM_W'(pf) * NUM_W'(period)) << FRAC_W;
    end
  end

  always_comb begin
    case (cmd.op)
      OP_P:    begin dnum = num_p; dden = den; end
      OP_Q1:   begin dnum = num_i; dden = den; end
      OP_I:    begin dnum = q1;    dden = DEN_W'(period); end
      OP_D:    begin dnum = num_d; dden = den; end
      default: begin dnum = num_p; dden = den; end
    endcase
  end

  assign qsat = (dquo[NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : dquo[31:0];

  rpa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (dnum),
    .den   (dden),
    .done  (ddone),
    .quo   (dquo)
  );

  always_ff @(posedge clk) begin
    if (cmd.emit) res <= stage;
  end

endmodule

[rtl/rpa_ctrl.sv]
// ----------------------------------------------------------------------------
// rpa_ctrl
// Controller: item sequencing, gain division order and output handshake.
// ----------------------------------------------------------------------------
module rpa_ctrl import rpa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t  state, state_next;
  div_op_t op, op_next;
  logic    emit_ok;

  assign emit_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_P;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.emit)      out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.finish ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        op_next    = OP_P;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_go = 1'b1;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        cmd.div_store = 1'b1;
        if (status.div_done) begin
          case (op)
            OP_P:    op_next = OP_Q1;
            OP_Q1:   op_next = OP_I;
            OP_I:    op_next = OP_D;
            default: op_next = OP_P;
          endcase
          state_next = (op == OP_D) ? S_EMIT : S_DSTART;
        end
      end
      S_EMIT: begin
        cmd.emit = emit_ok;
        if (emit_ok) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/relay_pid_autotune.sv]
// ----------------------------------------------------------------------------
// relay_pid_autotune
// Relay autotuner for a heater with Ziegler-Nichols PID gain output.
// ----------------------------------------------------------------------------
// Each input item yields one result item. An accepted item is registered,
// evaluated in S_EVAL into the stage register, and copied to the output
// register in S_EMIT; no new item is taken until then. The sample item that
// ends the tuning also passes through S_MUL and the divisions: the gains come
// from four 66-bit divisions through one shared restoring divider at one
// quotient bit per cycle. The next item is accepted while a result waits in
// the output register. Gains are unsigned Q16.16 and saturate at all ones.
module relay_pid_autotune import rpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  rpa_in_if.sink     in_ch,
  rpa_out_if.source  out_ch
);

  in_t     in_item;
  res_t    res;
  cmd_t    cmd;
  status_t status;

  assign in_item.cmd          = in_ch.cmd;
  assign in_item.current_temp = in_ch.current_temp;
  assign in_item.target_temp  = in_ch.target_temp;
  assign in_item.now_ms       = in_ch.now_ms;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (reg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .res       (res)
  );

  assign out_ch.heater_power  = res.heater_power;
  assign out_ch.heater_update = res.heater_update;
  assign out_ch.busy_res      = res.busy_res;
  assign out_ch.done_res      = res.done_res;
  assign out_ch.aborted       = res.aborted;
  assign out_ch.gain_p        = res.gain_p;
  assign out_ch.gain_i        = res.gain_i;
  assign out_ch.gain_d        = res.gain_d;

endmodule
